>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the timer scheduler checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every rising clock edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);

`endif

>>> rtl/core/dts_pkg.sv
// ----------------------------------------------------------------------------
// dts_pkg
// types and constants shared by the deadline timer scheduler modules
// ----------------------------------------------------------------------------
`default_nettype none

package dts_pkg;

  localparam int NUM_TIMERS_DEF = 16;
  localparam int TIME_BITS_DEF  = 48;

  localparam int KIND_W   = 2;
  localparam int ID_W     = 4;
  localparam int DELAY_W  = 32;
  localparam int PERIOD_W = 32;
  localparam int NOW_W    = 48;
  localparam int ORDER_W  = 64;
  localparam int WAIT_W   = 32;

  localparam logic [KIND_W-1:0] KIND_START = 2'd0;
  localparam logic [KIND_W-1:0] KIND_STOP  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

  localparam logic [WAIT_W-1:0] WAIT_NONE = '1;
  localparam logic [WAIT_W-1:0] WAIT_MAX  = 32'h7fff_ffff;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [ID_W-1:0]     timer_id;
    logic [DELAY_W-1:0]  delay;
    logic [PERIOD_W-1:0] repeat_interval;
    logic [NOW_W-1:0]    now;
  } in_item_t;

  typedef struct packed {
    logic                     fired;
    logic [ID_W-1:0]          fired_id;
    logic signed [WAIT_W-1:0] wait_ms;
    logic                     last;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic latch;      // take the input item and apply start, stop or time load
    logic scan_go;    // begin a pass over the timer table
    logic scan_fire;  // pass looks only at expired timers not yet fired
    logic fire;       // fire the best timer and put its item in the output register
    logic emit_sum;   // put the closing summary item in the output register
  } dts_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_tick;
    logic scan_done;
    logic best_valid;
    logic out_free;
  } dts_status_t;

endpackage

`default_nettype wire

>>> rtl/core/dts_ram.sv
// ----------------------------------------------------------------------------
// dts_ram
// generic simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
`default_nettype none

module dts_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> rtl/core/dts_datapath.sv
// ----------------------------------------------------------------------------
// dts_datapath
// timer table, scan unit with running minimum, re-arm adder, output register
// ----------------------------------------------------------------------------
`default_nettype none

module dts_datapath #(
  parameter int NUM_TIMERS = 16,
  parameter int TIME_BITS  = 48
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dts_pkg::in_item_t   in_data,
  input  wire dts_pkg::dts_cmd_t   cmd,
  output dts_pkg::dts_status_t     st,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output dts_pkg::out_item_t       out_data
);

  import dts_pkg::*;

  localparam int IDX_W = $clog2(NUM_TIMERS);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(NUM_TIMERS - 1);

  logic [TIME_BITS-1:0]  cur_time;
  logic [ORDER_W-1:0]    order_counter;
  logic [NUM_TIMERS-1:0] active;
  logic [NUM_TIMERS-1:0] done;

  // scan sequencing
  logic             scan_run;
  logic             scan_fire;
  logic [IDX_W-1:0] scan_idx;
  logic             rd_vld;
  logic [IDX_W-1:0] rd_idx;

  // running minimum
  logic                 best_valid;
  logic [IDX_W-1:0]     best_idx;
  logic [TIME_BITS-1:0] best_deadline;
  logic [ORDER_W-1:0]   best_order;
  logic [PERIOD_W-1:0]  best_period;

  logic [TIME_BITS-1:0] rd_deadline;
  logic [PERIOD_W-1:0]  rd_period;
  logic [ORDER_W-1:0]   rd_order;

  logic                 in_ok;
  logic [IDX_W-1:0]     in_idx;
  logic                 do_start;
  logic                 do_stop;
  logic                 rearm;
  logic                 wr_en;
  logic [IDX_W-1:0]     wr_idx;
  logic [PERIOD_W-1:0]  wr_period;
  logic [PERIOD_W-1:0]  add_off;
  logic [TIME_BITS:0]   add_sum;
  logic [TIME_BITS-1:0] sat_deadline;
  logic                 eligible;
  logic                 better;
  logic [TIME_BITS-1:0] diff;
  logic [WAIT_W-1:0]    wait_val;

  assign in_ok    = 32'(in_data.timer_id) < 32'(NUM_TIMERS);
  assign in_idx   = IDX_W'(in_data.timer_id);
  assign do_start = cmd.latch && (in_data.kind == KIND_START) && in_ok;
  assign do_stop  = cmd.latch && (in_data.kind == KIND_STOP) && in_ok;
  assign rearm    = (best_period != '0) && (best_period != '1);

  // one saturating adder serves both start and re-arm
  assign add_off      = cmd.fire ? best_period : in_data.delay;
  assign add_sum      = {1'b0, cur_time} + (TIME_BITS + 1)'(add_off);
  assign sat_deadline = add_sum[TIME_BITS] ? '1 : add_sum[TIME_BITS-1:0];

  assign wr_en     = do_start || (cmd.fire && rearm);
  assign wr_idx    = cmd.fire ? best_idx : in_idx;
  assign wr_period = cmd.fire ? best_period : in_data.repeat_interval;

  dts_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_TIMERS)) u_deadline_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (sat_deadline),
    .raddr (scan_idx),
    .rdata (rd_deadline)
  );

  dts_ram #(.WIDTH(PERIOD_W), .DEPTH(NUM_TIMERS)) u_period_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (wr_period),
    .raddr (scan_idx),
    .rdata (rd_period)
  );

  dts_ram #(.WIDTH(ORDER_W), .DEPTH(NUM_TIMERS)) u_order_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (wr_idx),
    .wdata (order_counter),
    .raddr (scan_idx),
    .rdata (rd_order)
  );

  // firing pass only considers expired timers that have not fired this tick
  assign eligible = active[rd_idx] &&
                    (!scan_fire || (!done[rd_idx] && (rd_deadline <= cur_time)));
  assign better   = !best_valid || (rd_deadline < best_deadline) ||
                    ((rd_deadline == best_deadline) && (rd_order < best_order));

  assign diff = best_deadline - cur_time;

  always_comb begin
    if (!best_valid) begin
      wait_val = WAIT_NONE;
    end else if (best_deadline <= cur_time) begin
      wait_val = '0;
    end else if (|diff[TIME_BITS-1:WAIT_W-1]) begin
      wait_val = WAIT_MAX;
    end else begin
      wait_val = {1'b0, diff[WAIT_W-2:0]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_time      <= '0;
      order_counter <= '0;
      active        <= '0;
      done          <= '0;
      scan_run      <= 1'b0;
      scan_fire     <= 1'b0;
      scan_idx      <= '0;
      rd_vld        <= 1'b0;
      rd_idx        <= '0;
      best_valid    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cmd.latch && (in_data.kind == KIND_TICK)) begin
        cur_time <= TIME_BITS'(in_data.now);
        done     <= '0;
      end
      if (do_stop) begin
        active[in_idx] <= 1'b0;
      end
      if (do_start) begin
        active[in_idx] <= 1'b1;
      end
      if (cmd.fire) begin
        done[best_idx] <= 1'b1;
        if (!rearm) begin
          active[best_idx] <= 1'b0;
        end
      end
      if (do_start || (cmd.fire && rearm)) begin
        order_counter <= order_counter + 1'b1;
      end

      if (cmd.scan_go) begin
        scan_run   <= 1'b1;
        scan_fire  <= cmd.scan_fire;
        scan_idx   <= '0;
        best_valid <= 1'b0;
      end else if (scan_run) begin
        scan_idx <= scan_idx + 1'b1;
        if (scan_idx == IDX_LAST) begin
          scan_run <= 1'b0;
        end
      end
      rd_vld <= scan_run && !cmd.scan_go;
      rd_idx <= scan_idx;
      if (rd_vld && eligible && better) begin
        best_valid <= 1'b1;
      end

      if (cmd.fire || cmd.emit_sum) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_vld && eligible && better) begin
      best_idx      <= rd_idx;
      best_deadline <= rd_deadline;
      best_order    <= rd_order;
      best_period   <= rd_period;
    end
    if (cmd.fire) begin
      out_data.fired    <= 1'b1;
      out_data.fired_id <= ID_W'(best_idx);
      out_data.wait_ms  <= '0;
      out_data.last     <= 1'b0;
    end else if (cmd.emit_sum) begin
      out_data.fired    <= 1'b0;
      out_data.fired_id <= '0;
      out_data.wait_ms  <= wait_val;
      out_data.last     <= 1'b1;
    end
  end

  assign st.in_tick    = in_data.kind == KIND_TICK;
  assign st.scan_done  = rd_vld && (rd_idx == IDX_LAST);
  assign st.best_valid = best_valid;
  assign st.out_free   = !out_valid || !out_stall;

endmodule

`default_nettype wire

>>> rtl/core/dts_ctrl.sv
// ----------------------------------------------------------------------------
// dts_ctrl
// sequencer: accept, firing passes, summary pass, result hand-off
// ----------------------------------------------------------------------------
`default_nettype none

module dts_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire dts_pkg::dts_status_t st,
  output dts_pkg::dts_cmd_t         cmd
);

  import dts_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_FIRE,
    S_FIRE,
    S_SCAN_SUM,
    S_EMIT
  } state_t;

  state_t state;
  state_t state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch     = 1'b1;
          cmd.scan_go   = 1'b1;
          cmd.scan_fire = st.in_tick;
          state_next    = st.in_tick ? S_SCAN_FIRE : S_SCAN_SUM;
        end
      end
      S_SCAN_FIRE: begin
        if (st.scan_done) begin
          state_next = S_FIRE;
        end
      end
      S_FIRE: begin
        if (!st.best_valid) begin
          cmd.scan_go = 1'b1;
          state_next  = S_SCAN_SUM;
        end else if (st.out_free) begin
          // fire this one and look for the next expired timer
          cmd.fire      = 1'b1;
          cmd.scan_go   = 1'b1;
          cmd.scan_fire = 1'b1;
          state_next    = S_SCAN_FIRE;
        end
      end
      S_SCAN_SUM: begin
        if (st.scan_done) begin
          state_next = S_EMIT;
        end
      end
      S_EMIT: begin
        if (st.out_free) begin
          cmd.emit_sum = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = state != S_IDLE;

endmodule

`default_nettype wire

>>> rtl/core/deadline_timer_scheduler.sv
// ----------------------------------------------------------------------------
// deadline_timer_scheduler
// timer table with deadline-ordered expiry and next-deadline report
// ----------------------------------------------------------------------------
// usage:
//   in channel (in_valid/in_stall/in_data) takes start, stop and tick items.
//   out channel (out_valid/out_stall/out_data) returns, per input item, one
//   fired item per expired timer (tick only, earliest deadline first, ties
//   to the earlier start or re-arm) and then one summary item with last
//   set that carries the wait to the nearest deadline.
//   one item is worked at a time; every pass over the timer table reads the
//   deadline, period and order memories one entry a cycle. a start or stop
//   runs one summary pass; a tick that fires k timers runs k + 1 firing
//   passes and then one summary pass.
//   in_stall is high from the accept until the summary item sits in the
//   output register; the next item is taken while that summary waits.
//   a stalled receiver holds the output register and the sequencer waits.
//   reset clears time, order count and all active marks; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module deadline_timer_scheduler #(
  parameter int NUM_TIMERS = dts_pkg::NUM_TIMERS_DEF,
  parameter int TIME_BITS  = dts_pkg::TIME_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire dts_pkg::in_item_t  in_data,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output dts_pkg::out_item_t      out_data
);

  import dts_pkg::*;

  dts_cmd_t    cmd;
  dts_status_t st;

  dts_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  dts_datapath #(
    .NUM_TIMERS (NUM_TIMERS),
    .TIME_BITS  (TIME_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

>>> rtl/core/dts_checker.sv
// ----------------------------------------------------------------------------
// dts_checker
// port-level checks for the deadline timer scheduler, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module dts_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire dts_pkg::out_item_t out_data
);

  import dts_pkg::*;

  `ASSERT_PROP(a_out_hold, clk, rst, out_valid && out_stall |=> out_valid && $stable(out_data), "stalled output item changed")

  // only the summary closes an item, and it never reports a firing
  `ASSERT_NEVER(a_last_fired, clk, rst, out_valid && (out_data.last == out_data.fired), "last and fired disagree")

  `ASSERT_NEVER(a_fired_wait, clk, rst, out_valid && out_data.fired && (out_data.wait_ms != '0), "fired item with nonzero wait")

  // one item at a time: an accept is followed by a busy cycle
  `ASSERT_PROP(a_busy_after_accept, clk, rst, in_valid && !in_stall |=> in_stall, "accepted two items back to back")

endmodule

bind deadline_timer_scheduler dts_checker u_dts_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
